// ===== hw/rtl/mbr_pkg.sv =====
// Package: shared types, constants and command/status structs for the MBR table parser.
package mbr_pkg;

  localparam int unsigned SectorBytes  = 512;
  localparam int unsigned TableEntries = 4;
  localparam int unsigned PosW         = $clog2(SectorBytes);
  localparam int unsigned IdxW         = $clog2(TableEntries);

  localparam logic [PosW-1:0] TableFirstPos = 9'd446;
  localparam logic [PosW-1:0] TableEndPos   = 9'd510;  // one past the last table byte
  localparam logic [PosW-1:0] SigLowPos     = 9'd510;
  localparam logic [PosW-1:0] SigHighPos    = 9'd511;

  localparam logic [7:0] SigLowValue  = 8'h55;
  localparam logic [7:0] SigHighValue = 8'hAA;
  localparam logic [7:0] EmptyType    = 8'h00;
  localparam int unsigned BootBit     = 7;  // status byte mask 0x80

  // Byte offsets inside one 16-byte table entry
  localparam logic [3:0] OffStatus   = 4'd0;
  localparam logic [3:0] OffType     = 4'd4;
  localparam logic [3:0] OffLbaFirst = 4'd8;
  localparam logic [3:0] OffCntFirst = 4'd12;

  typedef logic [2:0] max_t;
  typedef logic [2:0] count_t;

  typedef struct packed {
    logic [7:0] sector_byte;
    logic       read_error;
  } in_t;

  typedef struct packed {
    logic        entry_valid;
    logic [7:0]  partition_type;
    logic        bootable;
    logic [31:0] first_lba;
    logic [31:0] sector_total;
    count_t      entry_count;
    logic        last;
  } out_t;

  // Controller -> datapath
  typedef struct packed {
    logic take_byte;  // an input transaction completes this cycle
    logic emit;       // load the next result into the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last_byte;  // current position is the final sector byte
    logic out_free;   // output register can take a result this cycle
    logic emit_last;  // the result offered now closes the sector
  } status_t;

  typedef enum logic [1:0] {
    S_RECV = 2'b01,
    S_EMIT = 2'b10
  } state_e;

endpackage

// ===== hw/rtl/mbr_if.sv =====
// Interfaces: valid/ready channels for sector bytes in and table results out.
interface mbr_in_if;
  import mbr_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mbr_out_if;
  import mbr_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mbr_dp.sv =====
// Datapath: byte position, entry capture, signature check and result register.
module mbr_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbr_pkg::cmd_t    cmd_i,
  output mbr_pkg::status_t st_o,
  input  mbr_pkg::in_t     in_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output mbr_pkg::out_t    out_data_o,
  input  logic             cfg_we_i,
  input  mbr_pkg::max_t    cfg_wdata_i
);
  import mbr_pkg::*;

  logic [PosW-1:0]         pos_q;
  logic [PosW-1:0]         rel;
  logic                    in_table;
  logic [IdxW-1:0]         wr_idx;
  logic [3:0]              wr_off;
  logic [1:0]              wr_lane;
  logic [7:0]              sig_low_q;
  logic                    err_q;
  max_t                    max_q;

  logic                    boot_q  [TableEntries];
  logic [7:0]              ptype_q [TableEntries];
  logic [31:0]             lba_q   [TableEntries];
  logic [31:0]             cnt_q   [TableEntries];

  logic [TableEntries-1:0] qual;
  logic                    sig_ok;
  logic [TableEntries-1:0] mask_q;
  count_t                  n_q;
  logic [IdxW-1:0]         pick;
  logic [TableEntries-1:0] rest;
  count_t                  n_next;
  logic                    empty;
  logic                    emit_last;
  out_t                    res;
  logic                    out_vld_q;
  out_t                    out_q;

  // Position within the table and byte lane within a 32-bit field
  assign rel      = pos_q - TableFirstPos;
  assign in_table = (pos_q >= TableFirstPos) && (pos_q < TableEndPos);
  assign wr_idx   = rel[IdxW+3:4];
  assign wr_off   = rel[3:0];
  assign wr_lane  = wr_off[1:0];

  // Byte counter, signature low byte, sticky read error, config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sig_low_q <= '0;
      err_q     <= 1'b0;
      max_q     <= 3'd4;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (cmd_i.take_byte) begin
        if (pos_q == SigHighPos) begin
          pos_q     <= '0;
          sig_low_q <= '0;
          err_q     <= 1'b0;
        end else begin
          pos_q <= pos_q + 1'b1;
          if (in_data_i.read_error) begin
            err_q <= 1'b1;
          end
          if (pos_q == SigLowPos) begin
            sig_low_q <= in_data_i.sector_byte;
          end
        end
      end
    end
  end

  // Entry store: payload only, CHS bytes are skipped
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && in_table) begin
      if (wr_off == OffStatus) begin
        boot_q[wr_idx] <= in_data_i.sector_byte[BootBit];
      end else if (wr_off == OffType) begin
        ptype_q[wr_idx] <= in_data_i.sector_byte;
      end else if (wr_off >= OffCntFirst) begin
        cnt_q[wr_idx][{wr_lane, 3'b000} +: 8] <= in_data_i.sector_byte;
      end else if (wr_off >= OffLbaFirst) begin
        lba_q[wr_idx][{wr_lane, 3'b000} +: 8] <= in_data_i.sector_byte;
      end
    end
  end

  // Sector check at the final byte
  assign sig_ok = (sig_low_q == SigLowValue) && (in_data_i.sector_byte == SigHighValue) &&
                  !err_q && !in_data_i.read_error;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      qual[i] = sig_ok && (ptype_q[i] != EmptyType) && (cnt_q[i] != '0);
    end
  end

  // Lowest pending entry
  always_comb begin
    pick = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        pick = IdxW'(i);
      end
    end
  end

  assign rest      = mask_q & ~(TableEntries'(1) << pick);
  assign n_next    = n_q + 1'b1;
  assign empty     = (mask_q == '0) || (max_q == '0);
  assign emit_last = empty || (rest == '0) || (n_next == max_q);

  always_comb begin
    res = '0;
    if (empty) begin
      res.last = 1'b1;
    end else begin
      res.entry_valid    = 1'b1;
      res.partition_type = ptype_q[pick];
      res.bootable       = boot_q[pick];
      res.first_lba      = lba_q[pick];
      res.sector_total   = cnt_q[pick];
      res.last           = emit_last;
      res.entry_count    = emit_last ? n_next : '0;
    end
  end

  // Pending mask and count of entries reported so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      n_q    <= '0;
    end else if (cmd_i.take_byte && pos_q == SigHighPos) begin
      mask_q <= qual;
      n_q    <= '0;
    end else if (cmd_i.emit) begin
      mask_q <= rest;
      n_q    <= n_next;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_data_o   = out_q;
  assign st_o.last_byte = (pos_q == SigHighPos);
  assign st_o.out_free  = !out_vld_q || out_ready_i;
  assign st_o.emit_last = emit_last;

  // Checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_vld_q || out_ready_i))
    else $error("result loaded over an untaken result");
  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !emit_last) |=> (mask_q != '0))
    else $error("non-final result left no pending entry");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= count_t'(TableEntries))
    else $error("reported entry count out of range");
  a_no_byte_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !cmd_i.take_byte)
    else $error("byte taken during result emission");

endmodule

// ===== hw/rtl/mbr_ctrl.sv =====
// Controller: alternates between taking sector bytes and emitting the results.
module mbr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output mbr_pkg::cmd_t    cmd_o,
  input  mbr_pkg::status_t st_i
);
  import mbr_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o     = (state_q == S_RECV);
  assign cmd_o.take_byte = in_valid_i && (state_q == S_RECV);
  assign cmd_o.emit      = (state_q == S_EMIT) && st_i.out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_RECV: begin
        if (cmd_o.take_byte && st_i.last_byte) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd_o.emit && st_i.emit_last) begin
          state_d = S_RECV;
        end
      end
      default: state_d = S_RECV;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_enter_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_byte && st_i.last_byte) |=> (state_q == S_EMIT))
    else $error("sector end did not start emission");
  a_leave_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && st_i.emit_last) |=> (state_q == S_RECV))
    else $error("final result did not return to byte intake");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

// ===== hw/rtl/mbr_partition_table_parser_top.sv =====
// Top level: MBR partition table parser, controller plus datapath.
//
//  channel  dir  fields                                         handshake
//  in_i     in   sector_byte, read_error                        valid/ready
//  out_o    out  entry_valid, partition_type, bootable,         valid/ready
//                first_lba, sector_total, entry_count, last
//  cfg      in   max_entries (cfg_wdata_i)                      cfg_we_i
//
// One byte per cycle is taken for all 512 bytes of a sector.
// After byte 511 intake pauses while results go out, one per cycle into the
// output register while it is free: one to four results per sector.
// A stalled output holds the emission; bytes resume once the last result is loaded.
// Reset clears the position, signature, error flag and sets max_entries to 4.
module mbr_partition_table_parser_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbr_in_if.sink        in_i,
  mbr_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  mbr_pkg::max_t cfg_wdata_i
);
  import mbr_pkg::*;

  cmd_t    cmd;
  status_t st;

  mbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  mbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
